// ----- sv/am_tone_modulator_defines.svh -----
// ----------------------------------------------------------------------------
// am_tone_modulator_defines
// Assertion macros shared by the AM tone modulator RTL.
// ----------------------------------------------------------------------------
`ifndef AM_TONE_MODULATOR_DEFINES_SVH
`define AM_TONE_MODULATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define AMTM_ASSERT_IMPLY(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("am_tone_modulator: check failed");

// next-cycle implication, sampled on clk, off during rst
`define AMTM_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("am_tone_modulator: check failed");

`endif

// ----- sv/amtm_pkg.sv -----
// ----------------------------------------------------------------------------
// amtm_pkg
// Widths, register codes, reset values and quarter-wave sine table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package amtm_pkg;

  localparam int PHASE_BITS     = 32;
  localparam int SINE_ADDR_BITS = 10;
  localparam int SAMPLE_BITS    = 16;

  localparam int TBL_N     = 1 << SINE_ADDR_BITS;
  localparam int ROM_AW    = SINE_ADDR_BITS + 1;
  localparam int SINE_BITS = 15;
  localparam int SIN_W     = SINE_BITS + 1;
  localparam int ENV_W     = 17;
  localparam int OP_A_W    = 18;
  localparam int PROD_W    = OP_A_W + SIN_W;
  localparam int ENV_SHIFT = 14;
  localparam int SMP_SHIFT = 30 - SAMPLE_BITS;
  localparam int ENV_ONE   = 16384;

  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int STEP_W     = 32;
  localparam int DEPTH_W    = 15;
  localparam int INDEX_W    = 24;

  localparam logic [STEP_W-1:0]  CARRIER_STEP_RST = 32'd97391549;
  localparam logic [STEP_W-1:0]  TONE_STEP_RST    = 32'd9739155;
  localparam logic [DEPTH_W-1:0] DEPTH_RST        = 15'd16384;
  localparam logic [INDEX_W-1:0] BURST_LENGTH_RST = 24'd88200;

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CARRIER_STEP = 2'd0,
    REG_TONE_STEP    = 2'd1,
    REG_DEPTH        = 2'd2,
    REG_BURST_LENGTH = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    MUL_ENV,
    MUL_SAMPLE
  } mul_mode_t;

  typedef logic [SINE_BITS-1:0] sine_tbl_t [0:TBL_N];

  function automatic sine_tbl_t build_sine_tbl();
    sine_tbl_t          tbl;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] sum;
    for (int k = 0; k <= TBL_N; k++) begin
      x    = (64'(k) * PI_HALF_Q30) >> SINE_ADDR_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 6; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n & 1) != 0) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      v = ($unsigned(sum) + 64'd32768) >> 16;
      if (v > 64'd16384) begin
        v = 64'd16384;
      end
      tbl[k] = SINE_BITS'(v);
    end
    return tbl;
  endfunction

  localparam sine_tbl_t SINE_TBL = build_sine_tbl();

endpackage

// ----- sv/amtm_sine_rom.sv -----
// ----------------------------------------------------------------------------
// amtm_sine_rom
// Quarter-wave sine table, Q1.14 magnitude, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amtm_sine_rom (
  input  logic                                 clk,
  input  logic [amtm_pkg::ROM_AW-1:0]          addr,
  output logic [amtm_pkg::SINE_BITS-1:0]       data
);

  always_ff @(posedge clk) begin
    data <= amtm_pkg::SINE_TBL[addr];
  end

endmodule

// ----- sv/amtm_mul_unit.sv -----
// ----------------------------------------------------------------------------
// amtm_mul_unit
// Shared signed multiplier with round-half-up scaling for envelope or sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amtm_mul_unit (
  input  amtm_pkg::mul_mode_t                   mode,
  input  logic signed [amtm_pkg::OP_A_W-1:0]    op_a,
  input  logic signed [amtm_pkg::SIN_W-1:0]     op_b,
  output logic signed [amtm_pkg::PROD_W-1:0]    result
);

  localparam logic signed [amtm_pkg::PROD_W-1:0] ENV_HALF =
    amtm_pkg::PROD_W'(1) <<< (amtm_pkg::ENV_SHIFT - 1);
  localparam logic signed [amtm_pkg::PROD_W-1:0] SMP_HALF =
    amtm_pkg::PROD_W'(1) <<< (amtm_pkg::SMP_SHIFT - 1);

  logic signed [amtm_pkg::PROD_W-1:0] prod;
  logic signed [amtm_pkg::PROD_W-1:0] biased;

  always_comb begin
    prod = amtm_pkg::PROD_W'(op_a) * amtm_pkg::PROD_W'(op_b);
    case (mode)
      amtm_pkg::MUL_ENV: begin
        biased = prod + ENV_HALF;
        result = biased >>> amtm_pkg::ENV_SHIFT;
      end
      amtm_pkg::MUL_SAMPLE: begin
        biased = prod + SMP_HALF;
        result = biased >>> amtm_pkg::SMP_SHIFT;
      end
      default: begin
        biased = prod;
        result = prod;
      end
    endcase
  end

endmodule

// ----- sv/am_tone_modulator.sv -----
// ----------------------------------------------------------------------------
// am_tone_modulator
// AM tone generator: two phase accumulators, a quarter-wave sine table and
// one shared multiplier forming (1 + depth*sin(tone)) * sin(carrier).
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_ready    restart
//   out      out  out_valid/out_ready  sample, last
//   cfg      in   cfg_write            cfg_index, cfg_data
//
// A request steps through ST_TONE, ST_CAR, ST_ENV and ST_OUT before in_ready
// returns; the result loads in ST_OUT, after two reads of the single sine table
// port and two passes through the one multiplier.
// in_ready is high only while the sequencer is idle.
// A full result register stalls the final step until the result is taken.
// rst restores the register reset values and clears phases and index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "am_tone_modulator_defines.svh"

module am_tone_modulator (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   restart,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [amtm_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                   last,
  input  logic                                   cfg_write,
  input  logic [amtm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [amtm_pkg::CFG_W-1:0]             cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TONE,
    ST_CAR,
    ST_ENV,
    ST_OUT
  } state_t;

  localparam int PB = amtm_pkg::PHASE_BITS;

  localparam logic signed [amtm_pkg::PROD_W-1:0] SMP_MAX =
    (amtm_pkg::PROD_W'(1) <<< (amtm_pkg::SAMPLE_BITS - 1)) - amtm_pkg::PROD_W'(1);
  localparam logic signed [amtm_pkg::PROD_W-1:0] SMP_MIN = -SMP_MAX - amtm_pkg::PROD_W'(1);

  state_t state;

  logic [amtm_pkg::STEP_W-1:0]  carrier_step;
  logic [amtm_pkg::STEP_W-1:0]  tone_step;
  logic [amtm_pkg::DEPTH_W-1:0] depth;
  logic [amtm_pkg::INDEX_W-1:0] burst_length;

  logic [PB-1:0]                       carrier_phase;
  logic [PB-1:0]                       tone_phase;
  logic [amtm_pkg::INDEX_W-1:0]        sample_index;
  logic signed [amtm_pkg::SIN_W-1:0]   s_tone;
  logic signed [amtm_pkg::SIN_W-1:0]   s_car;
  logic signed [amtm_pkg::ENV_W-1:0]   env;

  logic [PB-1:0]                         phase_sel;
  logic [amtm_pkg::SINE_ADDR_BITS-1:0]   tbl_idx;
  logic [amtm_pkg::ROM_AW-1:0]           rom_addr;
  logic [amtm_pkg::SINE_BITS-1:0]        rom_data;
  logic signed [amtm_pkg::SIN_W-1:0]     rom_mag;
  logic                                  sine_neg;
  logic signed [amtm_pkg::SIN_W-1:0]     sine_val;

  amtm_pkg::mul_mode_t                   mul_mode;
  logic signed [amtm_pkg::OP_A_W-1:0]    mul_a;
  logic signed [amtm_pkg::SIN_W-1:0]     mul_b;
  logic signed [amtm_pkg::PROD_W-1:0]    mul_res;
  logic signed [amtm_pkg::ENV_W-1:0]     env_next;
  logic signed [amtm_pkg::SAMPLE_BITS-1:0] sample_next;

  logic [amtm_pkg::INDEX_W-1:0] last_index;
  logic                         last_hit;
  logic                         out_load;

  // table address for the phase being looked up, sign for the phase now read out
  always_comb begin
    phase_sel = (state == ST_TONE) ? tone_phase : carrier_phase;
    tbl_idx   = phase_sel[PB-3 -: amtm_pkg::SINE_ADDR_BITS];
    if (phase_sel[PB-2]) begin
      rom_addr = amtm_pkg::ROM_AW'(amtm_pkg::TBL_N) - {1'b0, tbl_idx};
    end else begin
      rom_addr = {1'b0, tbl_idx};
    end
    rom_mag  = $signed({1'b0, rom_data});
    sine_neg = (state == ST_CAR) ? tone_phase[PB-1] : carrier_phase[PB-1];
    sine_val = sine_neg ? -rom_mag : rom_mag;
  end

  amtm_sine_rom u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  always_comb begin
    if (state == ST_OUT) begin
      mul_mode = amtm_pkg::MUL_SAMPLE;
      mul_a    = amtm_pkg::OP_A_W'(env);
      mul_b    = s_car;
    end else begin
      mul_mode = amtm_pkg::MUL_ENV;
      mul_a    = $signed({{(amtm_pkg::OP_A_W - amtm_pkg::DEPTH_W){1'b0}}, depth});
      mul_b    = s_tone;
    end
  end

  amtm_mul_unit u_mul (
    .mode   (mul_mode),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .result (mul_res)
  );

  always_comb begin
    env_next = amtm_pkg::ENV_W'(mul_res) + amtm_pkg::ENV_W'(amtm_pkg::ENV_ONE);
    if (mul_res > SMP_MAX) begin
      sample_next = amtm_pkg::SAMPLE_BITS'(SMP_MAX);
    end else if (mul_res < SMP_MIN) begin
      sample_next = amtm_pkg::SAMPLE_BITS'(SMP_MIN);
    end else begin
      sample_next = amtm_pkg::SAMPLE_BITS'(mul_res);
    end
    last_index = (burst_length == '0) ? '0 : burst_length - amtm_pkg::INDEX_W'(1);
    last_hit   = sample_index >= last_index;
    out_load   = (state == ST_OUT) && (!out_valid || out_ready);
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_step <= amtm_pkg::CARRIER_STEP_RST;
      tone_step    <= amtm_pkg::TONE_STEP_RST;
      depth        <= amtm_pkg::DEPTH_RST;
      burst_length <= amtm_pkg::BURST_LENGTH_RST;
    end else if (cfg_write) begin
      case (amtm_pkg::cfg_reg_t'(cfg_index))
        amtm_pkg::REG_CARRIER_STEP: carrier_step <= cfg_data[amtm_pkg::STEP_W-1:0];
        amtm_pkg::REG_TONE_STEP:    tone_step    <= cfg_data[amtm_pkg::STEP_W-1:0];
        amtm_pkg::REG_DEPTH:        depth        <= cfg_data[amtm_pkg::DEPTH_W-1:0];
        amtm_pkg::REG_BURST_LENGTH: burst_length <= cfg_data[amtm_pkg::INDEX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      carrier_phase <= '0;
      tone_phase    <= '0;
      sample_index  <= '0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (restart) begin
              carrier_phase <= '0;
              tone_phase    <= '0;
              sample_index  <= '0;
            end
            state <= ST_TONE;
          end
        end
        ST_TONE: begin
          state <= ST_CAR;
        end
        ST_CAR: begin
          s_tone <= sine_val;
          state  <= ST_ENV;
        end
        ST_ENV: begin
          s_car <= sine_val;
          env   <= env_next;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            sample    <= sample_next;
            last      <= last_hit;
            out_valid <= 1'b1;
            if (last_hit) begin
              carrier_phase <= '0;
              tone_phase    <= '0;
              sample_index  <= '0;
            end else begin
              carrier_phase <= carrier_phase + PB'(carrier_step);
              tone_phase    <= tone_phase + PB'(tone_step);
              sample_index  <= sample_index + amtm_pkg::INDEX_W'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `AMTM_ASSERT_NEXT(a_busy_after_request, in_valid && in_ready, !in_ready)
  `AMTM_ASSERT_NEXT(a_burst_wrap, out_load && last_hit, carrier_phase == '0 && tone_phase == '0 && sample_index == '0)
  `AMTM_ASSERT_NEXT(a_result_loaded, out_load, out_valid && last == $past(last_hit))

endmodule
